// ----- rtl/core/bale_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounded array list engine package
// Shared widths, operation codes, status codes and cell control type.
// ----------------------------------------------------------------------------
`default_nettype none

package bale_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int DATA_W       = 32;
   localparam int FUNC_W       = 3;
   localparam int POS_W        = 4;
   localparam int STATUS_W     = 2;
   localparam int ECOUNT_W     = 5;

   localparam logic [FUNC_W-1:0] FUNC_INS_HEAD = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INS_TAIL = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INS_POS  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REM_HEAD = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_REM_TAIL = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_REM_POS  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   // Per-request control broadcast to every cell of the row.
   typedef struct packed {
      logic ins_en;
      logic rem_en;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/core/bale_cell.sv -----
// ----------------------------------------------------------------------------
// Bounded array list cell
// Holds one list entry; shifts up from its left neighbor on insert and down
// from its right neighbor on remove, and offers its value when removed.
// ----------------------------------------------------------------------------
`default_nettype none

module bale_cell #(
   parameter int IDX_W = 4,
   parameter int INDEX = 0
) (
   input  wire logic                          clock,
   input  wire bale_pkg::cell_ctl_type        ctl,
   input  wire logic [IDX_W-1:0]              at,
   input  wire logic [bale_pkg::DATA_W-1:0]   value,
   input  wire logic [bale_pkg::DATA_W-1:0]   left_data,
   input  wire logic [bale_pkg::DATA_W-1:0]   right_data,
   output logic      [bale_pkg::DATA_W-1:0]   data,
   output logic      [bale_pkg::DATA_W-1:0]   hit_data
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [bale_pkg::DATA_W-1:0] data_ff;
   logic [bale_pkg::DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.ins_en) begin
         if (MY_IDX > at) begin
            data_in = left_data;
         end else if (MY_IDX == at) begin
            data_in = value;
         end
      end else if (ctl.rem_en) begin
         if (MY_IDX >= at) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign hit_data = (ctl.rem_en && MY_IDX == at) ? data_ff : '0;

endmodule

`default_nettype wire

// ----- rtl/core/bounded_array_list_engine.sv -----
// ----------------------------------------------------------------------------
// Bounded array list engine
// Ordered list of signed 32-bit values kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the req_ channel carries one operation in req_tuser
//   (insert head, insert tail, insert at position, remove head, remove tail,
//   remove at position) with a position and a value in req_tdata. Every
//   request gives exactly one response on the rsp_ channel: the removed
//   value and the entry count after the operation in rsp_tdata, and the
//   status (ok, full, empty, position out of range) in rsp_tuser.
//   rsp_tvalid rises in the cycle after acceptance. One request is taken
//   per cycle: all cells shift in parallel, so the operation completes in
//   the clock edge that accepts it and the response sits in an output
//   register. A stalled receiver holds that register; req_tready then stays
//   high only in the cycle the waiting response is taken.
//   Reset empties the list and drops any pending response; no clearing pass
//   is needed, since an entry is only read below the count.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_list_engine #(
   parameter int CAPACITY = bale_pkg::CAPACITY_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // position[3:0], value[35:4], zero pad
   input  wire logic [2:0]  req_tuser,  // func[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,  // removed_value[31:0], entry_count[36:32], pad
   output logic      [1:0]  rsp_tuser   // status[1:0]
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > bale_pkg::POS_W) ? CNT_W : bale_pkg::POS_W;
   localparam int DW    = bale_pkg::DATA_W;

   logic [bale_pkg::FUNC_W-1:0]   func;
   logic [bale_pkg::POS_W-1:0]    position;
   logic [DW-1:0]                 value;

   logic                          fire;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic [CMP_W-1:0]              pos_w;
   logic [CMP_W-1:0]              cnt_w;
   logic [CMP_W-1:0]              at_w;
   logic                          full;
   logic                          empty;
   logic                          ins_ok;
   logic                          rem_ok;
   logic [bale_pkg::STATUS_W-1:0] status;
   bale_pkg::cell_ctl_type        ctl;

   logic [DW-1:0]                 cell_q   [CAPACITY];
   logic [DW-1:0]                 cell_hit [CAPACITY];
   logic [DW-1:0]                 removed;

   logic                          rsp_valid_ff;
   logic [DW-1:0]                 rsp_removed_ff;
   logic [bale_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [bale_pkg::ECOUNT_W-1:0] rsp_count_ff;

   assign func     = req_tuser;
   assign position = req_tdata[3:0];
   assign value    = req_tdata[35:4];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;

   assign pos_w = CMP_W'(position);
   assign cnt_w = CMP_W'(count_ff);
   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   always_comb begin
      at_w   = '0;
      ins_ok = 1'b0;
      rem_ok = 1'b0;
      status = bale_pkg::ST_OK;
      unique case (func)
         bale_pkg::FUNC_INS_HEAD: begin
            at_w = '0;
            if (full) status = bale_pkg::ST_FULL;
            else      ins_ok = 1'b1;
         end
         bale_pkg::FUNC_INS_TAIL: begin
            at_w = cnt_w;
            if (full) status = bale_pkg::ST_FULL;
            else      ins_ok = 1'b1;
         end
         bale_pkg::FUNC_INS_POS: begin
            // A position at or past the end appends.
            at_w = (pos_w >= cnt_w) ? cnt_w : pos_w;
            if (full) status = bale_pkg::ST_FULL;
            else      ins_ok = 1'b1;
         end
         bale_pkg::FUNC_REM_HEAD: begin
            at_w = '0;
            if (empty) status = bale_pkg::ST_EMPTY;
            else       rem_ok = 1'b1;
         end
         bale_pkg::FUNC_REM_TAIL: begin
            at_w = cnt_w - CMP_W'(1);
            if (empty) status = bale_pkg::ST_EMPTY;
            else       rem_ok = 1'b1;
         end
         bale_pkg::FUNC_REM_POS: begin
            at_w = pos_w;
            if (empty)               status = bale_pkg::ST_EMPTY;
            else if (pos_w >= cnt_w) status = bale_pkg::ST_RANGE;
            else                     rem_ok = 1'b1;
         end
         default: begin
            at_w = '0;
         end
      endcase
   end

   assign ctl.ins_en = fire && ins_ok;
   assign ctl.rem_en = fire && rem_ok;

   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic [DW-1:0] left_data;
         logic [DW-1:0] right_data;
         if (i == 0) begin : g_first
            assign left_data = value;
         end else begin : g_mid_l
            assign left_data = cell_q[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_data = cell_q[i];
         end else begin : g_mid_r
            assign right_data = cell_q[i+1];
         end
         bale_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .at         (at_w[IDX_W-1:0]),
            .value      (value),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_q[i]),
            .hit_data   (cell_hit[i])
         );
      end
   endgenerate

   // Only the addressed cell drives a nonzero hit, so an OR collects it.
   always_comb begin
      removed = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         removed = removed | cell_hit[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.ins_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.rem_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_removed_ff <= removed;
         rsp_status_ff  <= status;
         rsp_count_ff   <= bale_pkg::ECOUNT_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_removed_ff};
   assign rsp_tuser  = rsp_status_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list count exceeds capacity");

   a_reject_holds : assert property (@(posedge clock) disable iff (reset)
      fire && status != bale_pkg::ST_OK |=> $stable(count_ff))
      else $error("rejected request changed the count");

   a_remove_dec : assert property (@(posedge clock) disable iff (reset)
      ctl.rem_en |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("successful remove did not decrement the count");

   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != bale_pkg::ST_OK |-> rsp_removed_ff == '0)
      else $error("failed request returned a nonzero value");

endmodule

`default_nettype wire
